// File: rtl/fixed_partition_first_fit_core_macros.svh
// assertion macros shared by the allocator rtl
`ifndef FIXED_PARTITION_FIRST_FIT_CORE_MACROS_SVH
`define FIXED_PARTITION_FIRST_FIT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FPFF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");
`define FPFF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");
`else
`define FPFF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FPFF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/fpff_pkg.sv
// types and codes of the fixed-partition first-fit allocator
package fpff_pkg;

  localparam int SIZE_W = 16;
  localparam int OWNER_W = 8;
  localparam int PIDX_W = 3;
  localparam int STATUS_W = 3;
  localparam int REG_IDX_W = 3;
  localparam int COUNT_W = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PLACED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_INTERNAL = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXTERNAL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_MEMORY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd5;

  localparam logic [REG_IDX_W-1:0] REG_PART_COUNT = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_UNPART = 3'd7;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] process_size;
    logic [OWNER_W-1:0] victim_id;
  } in_word_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PIDX_W-1:0]   partition_index;
    logic [OWNER_W-1:0]  issued_id;
    logic [SIZE_W-1:0]   internal_frag_total;
  } out_word_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] index;
    logic [SIZE_W-1:0]    data;
  } cfg_write_t;

  // request token walking down the row of partition cells
  typedef struct packed {
    logic               valid;
    logic               command;
    logic [SIZE_W-1:0]  size;
    logic [OWNER_W-1:0] victim;
    logic [OWNER_W-1:0] id;
    logic               done;
    logic [PIDX_W-1:0]  pidx;
    logic [SIZE_W-1:0]  delta;
    logic               internal;
  } token_t;

endpackage

// File: rtl/fpff_cell.sv
// one partition: its size, occupancy, owner and slack, and one token stage
`include "fixed_partition_first_fit_core_macros.svh"
module fpff_cell #(
  parameter int INDEX = 0
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fpff_pkg::cfg_write_t                 cfg,
  input  logic [fpff_pkg::COUNT_W-1:0]         partition_count,
  input  fpff_pkg::token_t                     tok_in,
  output fpff_pkg::token_t                     tok_out
);

  logic [fpff_pkg::SIZE_W-1:0]  size_reg;
  logic                         occ;
  logic [fpff_pkg::OWNER_W-1:0] owner;
  logic [fpff_pkg::SIZE_W-1:0]  slack;

  logic                         in_use;
  logic                         is_insert;
  logic                         hit_ins;
  logic                         hit_del;
  logic [fpff_pkg::SIZE_W-1:0]  fit_slack;
  fpff_pkg::token_t             tok_next;

  // counts above the row length still cover every cell
  assign in_use = partition_count > fpff_pkg::COUNT_W'(INDEX);
  assign is_insert = tok_in.command == fpff_pkg::CMD_INSERT;
  assign fit_slack = size_reg - tok_in.size;
  assign hit_ins = tok_in.valid && is_insert && !tok_in.done && in_use && !occ &&
                   (size_reg >= tok_in.size);
  assign hit_del = tok_in.valid && !is_insert && !tok_in.done && occ &&
                   (owner == tok_in.victim);

  always_comb begin
    tok_next = tok_in;
    if (hit_ins || hit_del) begin
      tok_next.done = 1'b1;
      tok_next.pidx = fpff_pkg::PIDX_W'(INDEX);
      tok_next.delta = hit_ins ? fit_slack : slack;
    end
    if (tok_in.valid && is_insert && in_use && (slack >= tok_in.size)) begin
      tok_next.internal = 1'b1;
    end
    if (rst) begin
      tok_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    tok_out <= tok_next;
    if (hit_ins) begin
      owner <= tok_in.id;
    end
    if (rst) begin
      size_reg <= '0;
      occ <= 1'b0;
      slack <= '0;
    end else begin
      if (cfg.we && cfg.index == fpff_pkg::REG_IDX_W'(INDEX)) begin
        size_reg <= cfg.data;
      end
      if (hit_ins) begin
        occ <= 1'b1;
        slack <= fit_slack;
      end else if (hit_del) begin
        occ <= 1'b0;
        slack <= '0;
      end
    end
  end

  `FPFF_ASSERT_NEXT(a_claim_sticks, clk, rst, hit_ins, occ && tok_out.done)
  `FPFF_ASSERT_NEXT(a_free_clears, clk, rst, hit_del, !occ && slack == '0)
  `FPFF_ASSERT_NEXT(a_done_passes, clk, rst, tok_in.valid && tok_in.done,
                    tok_out.done && tok_out.pidx == $past(tok_in.pidx))

endmodule

// File: rtl/fixed_partition_first_fit_core.sv
// Fixed-partition first-fit allocator. Each request word (insert or delete) is
// taken into a token that walks down a row of PARTITIONS cells, one cell per
// cycle; each cell owns one partition and claims or frees it as the token
// passes, and the tail logic then classifies the result, refusals included,
// and updates the saturating slack total. One request is in flight at a time:
// in_ready falls on acceptance and rises again once the result moves to the
// output register, so a new word is not taken until the previous result has
// passed the cell row and the pending register and moved into the output
// register. A stalled output holds in_ready low until the result can move. A
// finished result may sit in the output register while the next request is
// already being worked on. Configuration writes are registered and need no
// handshake.
`include "fixed_partition_first_fit_core_macros.svh"
module fixed_partition_first_fit_core #(
  parameter int PARTITIONS = 6,
  parameter int PROCESS_IDS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [fpff_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [fpff_pkg::SIZE_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  fpff_pkg::in_word_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output fpff_pkg::out_word_t                  out_data
);

  localparam int ID_W = (PROCESS_IDS > 2) ? $clog2(PROCESS_IDS) : 1;

  fpff_pkg::cfg_write_t         cfg;
  fpff_pkg::token_t             tok [0:PARTITIONS];
  fpff_pkg::token_t             tok_end;
  logic [PARTITIONS:0]          chain_valid;

  logic [fpff_pkg::COUNT_W-1:0] partition_count;
  logic [fpff_pkg::SIZE_W-1:0]  unpart;
  logic [fpff_pkg::SIZE_W-1:0]  total;
  logic [fpff_pkg::SIZE_W-1:0]  total_next;
  logic [ID_W-1:0]              next_id;
  logic                         busy;
  logic                         accept;
  fpff_pkg::out_word_t          pend;
  fpff_pkg::out_word_t          res;
  logic                         pend_valid;
  logic                         pend_move;

  logic [fpff_pkg::SIZE_W:0]    sum_add;
  logic [fpff_pkg::SIZE_W:0]    room;

  assign cfg.we = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data = cfg_data;

  assign in_ready = !busy;
  assign accept = in_valid && in_ready;
  assign tok_end = tok[PARTITIONS];
  assign pend_move = pend_valid && (!out_valid || out_ready);

  for (genvar g = 0; g < PARTITIONS; g++) begin : g_cell
    fpff_cell #(
      .INDEX(g)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .cfg(cfg),
      .partition_count(partition_count),
      .tok_in(tok[g]),
      .tok_out(tok[g+1])
    );
  end

  always_comb begin
    for (int k = 0; k <= PARTITIONS; k++) begin
      chain_valid[k] = tok[k].valid;
    end
  end

  // tail of the row: classify and update the total
  assign sum_add = {1'b0, total} + {1'b0, tok_end.delta};
  assign room = {1'b0, total} + {1'b0, unpart};

  always_comb begin
    res.partition_index = tok_end.pidx;
    res.issued_id = '0;
    total_next = total;
    if (tok_end.command == fpff_pkg::CMD_INSERT) begin
      res.issued_id = tok_end.id;
      if (tok_end.done) begin
        res.status = fpff_pkg::ST_PLACED;
        total_next = sum_add[fpff_pkg::SIZE_W] ? '1 : sum_add[fpff_pkg::SIZE_W-1:0];
      end else if (tok_end.internal) begin
        res.status = fpff_pkg::ST_INTERNAL;
      end else if (room >= {1'b0, tok_end.size}) begin
        res.status = fpff_pkg::ST_EXTERNAL;
      end else begin
        res.status = fpff_pkg::ST_NO_MEMORY;
      end
    end else if (tok_end.done) begin
      res.status = fpff_pkg::ST_REMOVED;
      total_next = (total >= tok_end.delta) ? total - tok_end.delta : '0;
    end else begin
      res.status = fpff_pkg::ST_NOT_ALLOC;
    end
    res.internal_frag_total = total_next;
  end

  always_ff @(posedge clk) begin
    tok[0].command <= in_data.command;
    tok[0].size <= in_data.process_size;
    tok[0].victim <= in_data.victim_id;
    tok[0].id <= fpff_pkg::OWNER_W'(next_id);
    tok[0].done <= 1'b0;
    tok[0].pidx <= '0;
    tok[0].delta <= '0;
    tok[0].internal <= 1'b0;
    if (tok_end.valid) begin
      pend <= res;
    end
    if (pend_move) begin
      out_data <= pend;
    end
    if (rst) begin
      tok[0].valid <= 1'b0;
      partition_count <= '0;
      unpart <= '0;
      total <= '0;
      next_id <= '0;
      busy <= 1'b0;
      pend_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      tok[0].valid <= accept;
      if (cfg_we && cfg_index == fpff_pkg::REG_PART_COUNT) begin
        partition_count <= cfg_data[fpff_pkg::COUNT_W-1:0];
      end
      if (cfg_we && cfg_index == fpff_pkg::REG_UNPART) begin
        unpart <= cfg_data;
      end
      // a failed insert still uses up its id
      if (accept && in_data.command == fpff_pkg::CMD_INSERT) begin
        next_id <= (next_id == ID_W'(PROCESS_IDS - 1)) ? '0 : next_id + 1'b1;
      end
      if (tok_end.valid) begin
        total <= total_next;
        pend_valid <= 1'b1;
      end else if (pend_move) begin
        pend_valid <= 1'b0;
      end
      if (accept) begin
        busy <= 1'b1;
      end else if (pend_move) begin
        busy <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `FPFF_ASSERT_NEXT(a_accept_starts, clk, rst, accept, busy && tok[0].valid)
  `FPFF_ASSERT_IMP(a_one_in_flight, clk, rst, 1'b1,
                   $countones({chain_valid, pend_valid}) <= 1)
  `FPFF_ASSERT_IMP(a_tail_while_busy, clk, rst, tok_end.valid, busy && !pend_valid)

endmodule
